@@ design/stereo_smoothed_predelay_dc_block_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stereo pre-delay DC block
// Clocked property wrappers used by the design files; all disable in reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_SMOOTHED_PREDELAY_DC_BLOCK_ASSERT_SVH
`define STEREO_SMOOTHED_PREDELAY_DC_BLOCK_ASSERT_SVH

// Same-cycle implication.
`define SSPDC_ASSERT_IMPL(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Next-cycle implication.
`define SSPDC_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

@@ design/sspdc_pkg.sv @@
// ----------------------------------------------------------------------------
// sspdc_pkg
// Shared constants and types of the stereo pre-delay with DC blocking.
// ----------------------------------------------------------------------------
`default_nettype none

package sspdc_pkg;

	localparam int STORE_DEPTH       = 16384;
	localparam int MAX_DELAY_SAMPLES = 12000;

	localparam int AW     = $clog2(STORE_DEPTH);
	localparam int FW     = 16;
	localparam int SW     = 24;
	localparam int YW     = 32;
	localparam int KW     = 16;
	localparam int DKW    = 24;
	localparam int MW     = $clog2(MAX_DELAY_SAMPLES + 1);
	localparam int DLY_W  = $clog2(MAX_DELAY_SAMPLES + 2) + FW;
	localparam int POS_W  = AW + FW;
	localparam int CMP_W  = ((DLY_W > POS_W) ? DLY_W : POS_W) + 1;

	localparam int AMOUNT_W  = 16;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_AMOUNT = REG_IDX_W'(0);

	localparam logic [KW-1:0]    SMOOTH_K  = 16'd41943;
	localparam logic [DKW-1:0]   DC_K      = 24'd16752050;
	localparam logic [MW-1:0]    MAX_DLY   = MW'(MAX_DELAY_SAMPLES);
	localparam logic [DLY_W-1:0] ONE_Q16   = DLY_W'(64'd1 << FW);
	localparam logic [POS_W-1:0] DLY_HI    = POS_W'(64'(STORE_DEPTH - 2) << FW);
	localparam logic [POS_W:0]   WRAP_POS  = (POS_W + 1)'(64'(STORE_DEPTH) << FW);
	localparam logic [AW-1:0]    LAST_ADDR = AW'(STORE_DEPTH - 1);

	typedef struct packed {
		logic [AW-1:0] addr0;
		logic [AW-1:0] addr1;
		logic [FW-1:0] frac;
		logic          ok0;
		logic          ok1;
	} sspdc_tap_t;

	typedef struct packed {
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic          rd_en;
		logic          mul_en;
		logic          interp_en;
		logic          out_en;
	} sspdc_lane_ctl_t;

endpackage

`default_nettype wire

@@ design/sspdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sspdc_ctrl
// Delay target, one-pole delay smoothing, write pointer and read tap addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module sspdc_ctrl import sspdc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [AMOUNT_W-1:0] delay_amount,
	input  logic                start,
	input  logic                addr_en,
	input  logic                advance,
	output logic [AW-1:0]       write_addr,
	output sspdc_tap_t          tap
);

	localparam int PW    = DLY_W + KW + 2;
	localparam int SM_SH = 24;
	localparam logic signed [PW-1:0] SM_RND = PW'(64'sd8388608);

	logic [2*AMOUNT_W-1:0]    sq_q;
	logic [2*AMOUNT_W+MW-1:0] scaled;
	logic [DLY_W-1:0]         tgt_q;
	logic [DLY_W-1:0]         smooth_q;
	logic signed [DLY_W:0]    diff;
	logic signed [PW-1:0]     dprod_q;
	logic signed [PW-1:0]     dsum;
	logic signed [PW-1:0]     snext;
	logic [AW-1:0]            wp_q;
	logic                     wrapped_q;
	logic [CMP_W-1:0]         sm_ext;
	logic [POS_W-1:0]         dly_c;
	logic [POS_W:0]           rp_raw;
	logic [POS_W:0]           rp_wrap;
	logic [POS_W-1:0]         pos;
	logic [AW-1:0]            i0;
	logic [AW-1:0]            i1;
	sspdc_tap_t               tap_q;

	// The target and the smoothing product are recomputed every cycle; the
	// top level holds off requests until they have settled after a write.
	assign scaled = sq_q * MAX_DLY;
	assign diff   = $signed({1'b0, tgt_q}) - $signed({1'b0, smooth_q});

	always_ff @(posedge clk) begin
		sq_q    <= delay_amount * delay_amount;
		tgt_q   <= ONE_Q16 + DLY_W'(scaled >> FW);
		dprod_q <= diff * $signed({1'b0, SMOOTH_K});
	end

	assign dsum  = dprod_q + SM_RND;
	assign snext = $signed({{(PW-DLY_W){1'b0}}, smooth_q}) + (dsum >>> SM_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q  <= ONE_Q16;
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else begin
			if (start) begin
				smooth_q <= snext[DLY_W-1:0];
			end
			if (advance) begin
				if (wp_q == LAST_ADDR) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
		end
	end

	// Clamp the delay for the read only; the smoothing state is left alone.
	assign sm_ext = CMP_W'(smooth_q);

	always_comb begin
		if (sm_ext < CMP_W'(ONE_Q16)) begin
			dly_c = POS_W'(ONE_Q16);
		end else if (sm_ext > CMP_W'(DLY_HI)) begin
			dly_c = DLY_HI;
		end else begin
			dly_c = POS_W'(smooth_q);
		end
	end

	assign rp_raw  = {1'b0, wp_q, {FW{1'b0}}} - {1'b0, dly_c};
	assign rp_wrap = rp_raw[POS_W] ? (rp_raw + WRAP_POS) : rp_raw;
	assign pos     = rp_wrap[POS_W-1:0];
	assign i0      = pos[POS_W-1:FW];
	assign i1      = (i0 == LAST_ADDR) ? '0 : i0 + 1'b1;

	// Entries are written in address order from reset, so an entry past the
	// write pointer before the first wrap is unwritten and is masked to zero.
	always_ff @(posedge clk) begin
		if (addr_en) begin
			tap_q.addr0 <= i0;
			tap_q.addr1 <= i1;
			tap_q.frac  <= pos[FW-1:0];
			tap_q.ok0   <= wrapped_q || (i0 <= wp_q);
			tap_q.ok1   <= wrapped_q || (i1 <= wp_q);
		end
	end

	assign write_addr = wp_q;
	assign tap        = tap_q;

endmodule

`default_nettype wire

@@ design/sspdc_lane.sv @@
// ----------------------------------------------------------------------------
// sspdc_lane
// One channel: delay store, linear interpolation and DC blocker.
// ----------------------------------------------------------------------------
`default_nettype none

module sspdc_lane import sspdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sspdc_lane_ctl_t       ctl,
	input  sspdc_tap_t            tap,
	input  logic signed [SW-1:0]  sample,
	output logic signed [SW-1:0]  wet
);

	localparam int IPW = SW + FW + 2;
	localparam int DPW = YW + DKW + 1;
	localparam int ZW  = YW + 2;
	localparam logic signed [IPW-1:0] IP_RND  = IPW'(64'sd32768);
	localparam logic signed [DPW-1:0] DC_BIAS = DPW'(64'sd16777215);
	localparam logic signed [ZW-1:0]  Y_HI    = ZW'(64'sd2147483647);
	localparam logic signed [ZW-1:0]  Y_LO    = ZW'(-64'sd2147483648);
	localparam logic signed [ZW-1:0]  S_HI    = ZW'(64'sd8388607);
	localparam logic signed [ZW-1:0]  S_LO    = ZW'(-64'sd8388608);

	logic [SW-1:0]           mem [STORE_DEPTH];
	logic [SW-1:0]           raw0_s1;
	logic [SW-1:0]           raw1_s1;
	logic signed [SW-1:0]    x0m;
	logic signed [SW-1:0]    x1m;
	logic signed [SW:0]      dx;
	logic signed [SW-1:0]    x0_s2;
	logic signed [IPW-1:0]   ip_s2;
	logic signed [DPW-1:0]   dcp_s2;
	logic signed [IPW-1:0]   ip_rnd;
	logic signed [IPW-1:0]   p_full;
	logic signed [DPW-1:0]   dcp_adj;
	logic signed [DPW-1:0]   dct_full;
	logic signed [SW-1:0]    p_s3;
	logic signed [YW-1:0]    dct_s3;
	logic signed [SW-1:0]    px_q;
	logic signed [YW-1:0]    py_q;
	logic signed [ZW-1:0]    z;
	logic signed [YW-1:0]    y_clamp;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= sample;
		end
		if (ctl.rd_en) begin
			raw0_s1 <= mem[tap.addr0];
			raw1_s1 <= mem[tap.addr1];
		end
	end

	assign x0m = tap.ok0 ? $signed(raw0_s1) : '0;
	assign x1m = tap.ok1 ? $signed(raw1_s1) : '0;
	assign dx  = (SW + 1)'(x1m) - (SW + 1)'(x0m);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			x0_s2  <= x0m;
			ip_s2  <= dx * $signed({1'b0, tap.frac});
			dcp_s2 <= py_q * $signed({1'b0, DC_K});
		end
	end

	// Interpolation rounds half up; the feedback product truncates toward zero.
	assign ip_rnd   = ip_s2 + IP_RND;
	assign p_full   = IPW'(x0_s2) + (ip_rnd >>> FW);
	assign dcp_adj  = dcp_s2[DPW-1] ? (dcp_s2 + DC_BIAS) : dcp_s2;
	assign dct_full = dcp_adj >>> DKW;

	always_ff @(posedge clk) begin
		if (ctl.interp_en) begin
			p_s3   <= p_full[SW-1:0];
			dct_s3 <= dct_full[YW-1:0];
		end
	end

	assign z = ZW'(p_s3) - ZW'(px_q) + ZW'(dct_s3);

	always_comb begin
		if (z > Y_HI) begin
			y_clamp = Y_HI[YW-1:0];
		end else if (z < Y_LO) begin
			y_clamp = Y_LO[YW-1:0];
		end else begin
			y_clamp = z[YW-1:0];
		end
		if (z > S_HI) begin
			wet = S_HI[SW-1:0];
		end else if (z < S_LO) begin
			wet = S_LO[SW-1:0];
		end else begin
			wet = z[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
		end else if (ctl.out_en) begin
			px_q <= p_s3;
			py_q <= y_clamp;
		end
	end

endmodule

`default_nettype wire

@@ design/stereo_smoothed_predelay_dc_block.sv @@
// ----------------------------------------------------------------------------
// stereo_smoothed_predelay_dc_block
// Each request carries a stereo sample pair that is written into two circular
// pre-delay stores; the block returns one wet pair per request, read back at a
// smoothed fractional delay with linear interpolation and passed through a DC
// blocker. Requests are processed one at a time: the address calculation, the
// registered read of both store taps, the interpolation and feedback
// multipliers and the blocker sum run in turn on both channel lanes side by
// side, and the last step waits while the previous result is not yet taken.
// A new request is taken while the previous result still waits on the output.
// After reset and after every register write the input is held off while the
// delay target and smoothing step settle. The stores need no clearing pass:
// entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_smoothed_predelay_dc_block_assert.svh"

module stereo_smoothed_predelay_dc_block import sspdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  logic signed [SW-1:0] left_sample,
	input  logic signed [SW-1:0] right_sample,
	output logic                 wet_valid,
	input  logic                 wet_ready,
	output logic signed [SW-1:0] left_wet_feed,
	output logic signed [SW-1:0] right_wet_feed
);

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
	localparam logic [ST_W-1:0] ST_ADDR   = 3'd1;
	localparam logic [ST_W-1:0] ST_READ   = 3'd2;
	localparam logic [ST_W-1:0] ST_MUL    = 3'd3;
	localparam logic [ST_W-1:0] ST_INTERP = 3'd4;
	localparam logic [ST_W-1:0] ST_OUT    = 3'd5;

	localparam int SETTLE_W = 2;
	localparam logic [SETTLE_W-1:0] SETTLE_CYC = 2'd3;

	logic [ST_W-1:0]       state_q;
	logic [ST_W-1:0]       state_d;
	logic [SETTLE_W-1:0]   settle_q;
	logic [AMOUNT_W-1:0]   delay_amount_q;
	logic                  cfg_wr;
	logic                  cfg_hit;
	logic                  accept;
	logic                  finish;
	logic                  out_free;
	logic                  wet_valid_q;
	logic signed [SW-1:0]  left_wet_q;
	logic signed [SW-1:0]  right_wet_q;
	logic signed [SW-1:0]  left_wet;
	logic signed [SW-1:0]  right_wet;
	logic [AW-1:0]         write_addr;
	sspdc_tap_t            tap;
	sspdc_lane_ctl_t       lane_ctl;

	// Register port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_hit = (paddr[PADDR_W-1:2] == REG_DELAY_AMOUNT);
	assign prdata  = cfg_hit ? PDATA_W'(delay_amount_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_amount_q <= '0;
		end else if (cfg_wr && cfg_hit) begin
			delay_amount_q <= pwdata[AMOUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYC;
		end else if (cfg_wr) begin
			settle_q <= SETTLE_CYC;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// Sequencer.
	assign sample_ready = (state_q == ST_IDLE) && (settle_q == '0);
	assign accept       = sample_valid && sample_ready;
	assign out_free     = !wet_valid_q || wet_ready;
	assign finish       = (state_q == ST_OUT) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR:   state_d = ST_READ;
			ST_READ:   state_d = ST_MUL;
			ST_MUL:    state_d = ST_INTERP;
			ST_INTERP: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign lane_ctl.wr_en     = accept;
	assign lane_ctl.wr_addr   = write_addr;
	assign lane_ctl.rd_en     = (state_q == ST_READ);
	assign lane_ctl.mul_en    = (state_q == ST_MUL);
	assign lane_ctl.interp_en = (state_q == ST_INTERP);
	assign lane_ctl.out_en    = finish;

	sspdc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.delay_amount (delay_amount_q),
		.start        (accept),
		.addr_en      (state_q == ST_ADDR),
		.advance      (finish),
		.write_addr   (write_addr),
		.tap          (tap)
	);

	sspdc_lane u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.tap    (tap),
		.sample (left_sample),
		.wet    (left_wet)
	);

	sspdc_lane u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.tap    (tap),
		.sample (right_sample),
		.wet    (right_wet)
	);

	// Merge both lanes into the output register.
	always_ff @(posedge clk) begin
		if (finish) begin
			left_wet_q  <= left_wet;
			right_wet_q <= right_wet;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_valid_q <= 1'b0;
		end else if (finish) begin
			wet_valid_q <= 1'b1;
		end else if (wet_ready) begin
			wet_valid_q <= 1'b0;
		end
	end

	assign wet_valid      = wet_valid_q;
	assign left_wet_feed  = left_wet_q;
	assign right_wet_feed = right_wet_q;

	`SSPDC_ASSERT_NEXT(a_accept_starts, accept, (state_q == ST_ADDR) && !sample_ready, "accepted request did not start the sequence")
	`SSPDC_ASSERT_NEXT(a_cfg_holds_input, cfg_wr, !sample_ready, "request taken right after a register write")
	`SSPDC_ASSERT_NEXT(a_finish_presents, finish, wet_valid && (state_q == ST_IDLE), "finished request not presented on the output")
	`SSPDC_ASSERT_IMPL(a_wet_source, $rose(wet_valid), $past(state_q == ST_OUT), "output became valid outside the output step")

endmodule

`default_nettype wire

@@ tb/sspdc_wet_checker.sv @@
// ----------------------------------------------------------------------------
// sspdc_wet_checker
// Watches the configuration port and both handshake channels of the stereo
// pre-delay DC block. It keeps its own copy of the delay lines, the smoothed
// delay and the blocker state, and computes the wet pair of every accepted
// request. Each returned wet pair is compared with the oldest pending pair.
// ----------------------------------------------------------------------------
module sspdc_wet_checker import sspdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	input  logic                 sample_valid,
	input  logic                 sample_ready,
	input  logic signed [SW-1:0] left_sample,
	input  logic signed [SW-1:0] right_sample,
	input  logic                 wet_valid,
	input  logic                 wet_ready,
	input  logic signed [SW-1:0] left_wet_feed,
	input  logic signed [SW-1:0] right_wet_feed,
	output int                   mismatch_count,
	output int                   pending
);

	typedef struct packed {
		logic signed [SW-1:0] left;
		logic signed [SW-1:0] right;
	} wet_pair_t;

	localparam longint SMOOTHING_COEF = 64'sd41943;
	localparam longint BLOCKER_COEF   = 64'sd16752050;
	localparam longint UNIT_DELAY_Q16 = 64'sd65536;
	localparam longint ROUND_Q24      = 64'sd8388608;
	localparam longint DELAY_CEIL_Q16 = longint'(STORE_DEPTH - 2) << 16;
	localparam longint WRAP_Q16       = longint'(STORE_DEPTH) << 16;
	localparam longint WET_MAX        = 64'sd8388607;
	localparam longint WET_MIN        = -64'sd8388608;
	localparam longint ACC_MAX        = 64'sd2147483647;
	localparam longint ACC_MIN        = -64'sd2147483648;

	logic signed [SW-1:0] left_line [STORE_DEPTH];
	logic signed [SW-1:0] right_line [STORE_DEPTH];
	int                   write_ptr;
	longint               delay_q16;
	logic [AMOUNT_W-1:0]  amount;
	longint               prev_in [2];
	longint               prev_out [2];
	wet_pair_t            pending_wet_pairs [$];
	wet_pair_t            oldest;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint blend_taps(input longint x0, input longint x1,
			input longint frac);
		return x0 + (((x1 - x0) * frac + 64'sd32768) >>> 16);
	endfunction

	// The feedback product is truncated toward zero so that the blocker
	// settles all the way to zero instead of sticking at a small offset.
	function automatic logic signed [SW-1:0] dc_block_channel(input int ch,
			input longint x);
		longint fb;
		longint y;
		fb = prev_out[ch] * BLOCKER_COEF;
		fb = (fb < 0) ? -((-fb) >>> 24) : (fb >>> 24);
		y = clamp(x - prev_in[ch] + fb, ACC_MIN, ACC_MAX);
		prev_in[ch] = x;
		prev_out[ch] = y;
		return SW'(clamp(y, WET_MIN, WET_MAX));
	endfunction

	function automatic wet_pair_t compute_wet_pair(input logic signed [SW-1:0] l,
			input logic signed [SW-1:0] r);
		longint    target;
		longint    dly;
		longint    pos;
		longint    frac;
		int        i0;
		int        i1;
		wet_pair_t res;
		target = UNIT_DELAY_Q16 +
			((longint'(amount) * longint'(amount) * MAX_DELAY_SAMPLES) >>> 16);
		delay_q16 += ((target - delay_q16) * SMOOTHING_COEF + ROUND_Q24) >>> 24;
		left_line[write_ptr] = l;
		right_line[write_ptr] = r;
		// Only the read position is clamped; the smoothed state is kept as is.
		dly = clamp(delay_q16, UNIT_DELAY_Q16, DELAY_CEIL_Q16);
		pos = (longint'(write_ptr) << 16) - dly;
		if (pos < 0) begin
			pos += WRAP_Q16;
		end
		i0 = int'((pos >>> 16) % STORE_DEPTH);
		i1 = (i0 + 1) % STORE_DEPTH;
		frac = pos & 64'sh0000_FFFF;
		res.left = dc_block_channel(0, blend_taps(left_line[i0], left_line[i1], frac));
		res.right = dc_block_channel(1, blend_taps(right_line[i0], right_line[i1], frac));
		write_ptr = (write_ptr + 1) % STORE_DEPTH;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				left_line[i] = '0;
				right_line[i] = '0;
			end
			write_ptr = 0;
			delay_q16 = UNIT_DELAY_Q16;
			amount = '0;
			prev_in[0] = 0;
			prev_in[1] = 0;
			prev_out[0] = 0;
			prev_out[1] = 0;
			pending_wet_pairs.delete();
			mismatch_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready &&
					paddr[PADDR_W-1:2] == REG_DELAY_AMOUNT) begin
				amount = pwdata[AMOUNT_W-1:0];
			end
			if (wet_valid && wet_ready) begin
				if (pending_wet_pairs.size() == 0) begin
					mismatch_count++;
					$display("%0t: wet pair %0d / %0d returned with no request pending",
						$time, left_wet_feed, right_wet_feed);
				end else begin
					oldest = pending_wet_pairs.pop_front();
					if (left_wet_feed !== oldest.left) begin
						mismatch_count++;
						$display("%0t: left_wet_feed expected %0d, got %0d",
							$time, oldest.left, left_wet_feed);
					end
					if (right_wet_feed !== oldest.right) begin
						mismatch_count++;
						$display("%0t: right_wet_feed expected %0d, got %0d",
							$time, oldest.right, right_wet_feed);
					end
				end
			end
			if (sample_valid && sample_ready) begin
				pending_wet_pairs.push_back(compute_wet_pair(left_sample, right_sample));
			end
			pending = pending_wet_pairs.size();
		end
	end

endmodule

@@ tb/stereo_smoothed_predelay_dc_block_tb.sv @@
// ----------------------------------------------------------------------------
// stereo_smoothed_predelay_dc_block_tb
// Drives stereo sample requests and delay_amount writes into the pre-delay DC
// block, with random gaps on the input and random stalls on the output. A
// short directed part covers the sample extremes and very short delays, then
// random phases run at several delay settings. The checker beside the block
// does all the comparing; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module stereo_smoothed_predelay_dc_block_tb;
	import sspdc_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(1);
	localparam logic signed [SW-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SW-1:0] SAMPLE_MIN = 24'sh800000;
	localparam int IDLE_LIMIT      = 4000;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int RANDOM_PHASES   = 7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	logic signed [SW-1:0] left_sample = '0;
	logic signed [SW-1:0] right_sample = '0;
	logic                 wet_valid;
	logic                 wet_ready = 1'b0;
	logic signed [SW-1:0] left_wet_feed;
	logic signed [SW-1:0] right_wet_feed;

	int                   mismatch_count;
	int                   pending;
	int                   idle_cycles = 0;
	int                   stall_left = 0;
	bit                   steady = 1'b0;
	logic signed [SW-1:0] last_left = '0;
	logic signed [SW-1:0] last_right = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stereo_smoothed_predelay_dc_block uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.wet_valid      (wet_valid),
		.wet_ready      (wet_ready),
		.left_wet_feed  (left_wet_feed),
		.right_wet_feed (right_wet_feed)
	);

	sspdc_wet_checker wet_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.wet_valid      (wet_valid),
		.wet_ready      (wet_ready),
		.left_wet_feed  (left_wet_feed),
		.right_wet_feed (right_wet_feed),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	// Mostly no gap or a short one, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			wet_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			wet_ready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			wet_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (wet_valid && wet_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** stereo_smoothed_predelay_dc_block: FAILED **");
				$finish;
			end
		end
	end

	// Called at a falling edge with the sample channel idle.
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx,
			input logic [PDATA_W-1:0] value);
		paddr <= {idx, 2'b00};
		pwdata <= value;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Called at a falling edge; returns at the falling edge after the request
	// was taken, with valid still high so that the next request can follow
	// without a gap.
	task automatic push_pair(input logic signed [SW-1:0] l,
			input logic signed [SW-1:0] r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		last_left = l;
		last_right = r;
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
	endtask

	task automatic push_shaped();
		logic signed [SW-1:0] l;
		logic signed [SW-1:0] r;
		int                   kind;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			l = SW'($urandom);
			r = SW'($urandom);
		end else if (kind < 65) begin
			l = SW'(int'($urandom_range(0, 4000)) - 2000);
			r = SW'(int'($urandom_range(0, 4000)) - 2000);
		end else if (kind < 85) begin
			// Held level, so the blocker output decays toward zero.
			l = last_left;
			r = last_right;
		end else begin
			l = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			r = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
		end
		push_pair(l, r);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [PDATA_W-1:0] amt;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The first request runs at the reset delay of exactly one sample, so
		// its second tap is the entry it has just written.
		push_pair(SAMPLE_MAX, SAMPLE_MAX);
		drain();

		// A small amount keeps the delay between one and two samples early on,
		// so the read position wraps below entry zero and the second tap wraps
		// from the top entry back to entry zero.
		apb_write(REG_DELAY_AMOUNT, 32'd700);
		push_pair(SAMPLE_MAX, SAMPLE_MAX);
		push_pair(SAMPLE_MIN, SAMPLE_MIN);
		push_pair(SAMPLE_MAX, SAMPLE_MIN);
		push_pair(SAMPLE_MIN, SAMPLE_MAX);
		push_pair('0, '0);
		push_pair(-24'sd1, 24'sd1);
		push_pair(24'sd1, -24'sd1);
		push_pair(SAMPLE_MAX, SAMPLE_MAX);
		push_pair(SAMPLE_MAX, SAMPLE_MAX);
		push_pair(SAMPLE_MAX, SAMPLE_MAX);
		push_pair(24'sh555555, 24'shAAAAAA);
		push_pair(24'shAAAAAA, 24'sh555555);
		push_pair(SAMPLE_MIN, SAMPLE_MIN);
		push_pair('0, '0);
		drain();

		// The write to the spare index must leave the amount at zero.
		apb_write(REG_DELAY_AMOUNT, 32'd0);
		apb_write(REG_SPARE, 32'hFFFF_FFFF);
		push_pair(SAMPLE_MAX, SAMPLE_MIN);
		push_pair(SAMPLE_MIN, SAMPLE_MAX);
		push_pair(SAMPLE_MIN, SAMPLE_MAX);
		push_pair('0, '0);
		push_pair(SAMPLE_MAX, SAMPLE_MAX);
		push_pair(-24'sd1, -24'sd1);
		push_pair(-24'sd1, -24'sd1);
		push_pair(24'sd1, 24'sd1);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: amt = 32'd65535;
				1: amt = 32'hFFFF_0000 | 32'd4000;
				2: amt = 32'd0;
				3: amt = 32'd12000;
				4: amt = 32'd1;
				5: amt = $urandom_range(0, 65535);
				default: amt = $urandom_range(0, 3000);
			endcase
			steady = ($urandom_range(0, 3) == 0);
			apb_write(REG_DELAY_AMOUNT, amt);
			repeat (ITEMS_PER_PHASE) push_shaped();
			drain();
		end

		steady = 1'b0;
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && pending == 0) begin
			$display("** stereo_smoothed_predelay_dc_block: PASSED **");
		end else begin
			$display("** stereo_smoothed_predelay_dc_block: FAILED **");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/sspdc_pkg.sv
design/sspdc_ctrl.sv
design/sspdc_lane.sv
design/stereo_smoothed_predelay_dc_block.sv
tb/sspdc_wet_checker.sv
tb/stereo_smoothed_predelay_dc_block_tb.sv
